@@ sv/qrv_pkg.sv @@
// Shared types and constants for the quaternion vector rotation block.
`timescale 1ns / 1ps

package qrv_pkg;

  localparam int VAL_W  = 16;
  localparam int MAG_W  = 30;   // normalized magnitude width
  localparam int ROOT_W = 31;   // square root width
  localparam int RAD_W  = 62;   // sum of squares width
  localparam int QUO_W  = 15;   // quotient width
  localparam int NLANE  = 3;

  localparam logic [QUO_W-1:0] ONE_Q14 = QUO_W'(16384);

  typedef struct packed {
    logic signed [VAL_W-1:0] quat_w;
    logic signed [VAL_W-1:0] quat_x;
    logic signed [VAL_W-1:0] quat_y;
    logic signed [VAL_W-1:0] quat_z;
    logic signed [VAL_W-1:0] vec_x;
    logic signed [VAL_W-1:0] vec_y;
    logic signed [VAL_W-1:0] vec_z;
  } item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] out_x;
    logic signed [VAL_W-1:0] out_y;
    logic signed [VAL_W-1:0] out_z;
    logic                    degenerate;
  } result_t;

endpackage

@@ sv/quaternion_rotate_vector.sv @@
// Top level of the quaternion vector rotation pipeline.
// Rotates a Q1.14 vector by a Q1.14 quaternion and scales the result to unit length.
// Throughput is one transaction per cycle unless a stalled result holds the pipeline.
// The path from acceptance to result is nine stages of exact rotation and normalization,
// 31 stages of the bit-per-stage square root, 15 stages of the bit-per-stage divider and
// the output register. A zero result gives a zero vector with degenerate set. When
// result_stall holds a waiting result the whole pipeline holds and item_stall rises.
`timescale 1ns / 1ps

module quaternion_rotate_vector import qrv_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int SIDE1_W = NLANE * MAG_W + NLANE + 1;
  localparam int SIDE2_W = NLANE + 1;

  logic adv;
  assign adv        = !(result_valid && result_stall);
  assign item_stall = !adv;

  // stage 1: products
  logic v1;
  logic signed [31:0] ww, xx, yy, zz, xa, yb, zc, yc, zb, za, xc, xb, ya;
  logic signed [15:0] w1, x1, y1, z1, a1, b1, c1;
  // stage 2: d, e, cross product
  logic v2;
  logic signed [33:0] d2, e2;
  logic signed [32:0] cx2, cy2, cz2;
  logic signed [15:0] w2, x2, y2, z2, a2, b2, c2;
  // stage 3: second products
  logic v3;
  logic signed [49:0] da3, db3, dc3, ex3, ey3, ez3, wx3, wy3, wz3;
  // stage 4: rotated vector
  logic v4;
  logic signed [51:0] r4 [NLANE];
  // stage 5: magnitudes
  logic v5, zero5;
  logic [50:0] m5 [NLANE];
  logic [50:0] mx5;
  logic [NLANE-1:0] neg5;
  // stage 6: leading one
  logic v6, zero6;
  logic [50:0] m6 [NLANE];
  logic [5:0]  p6;
  logic [NLANE-1:0] neg6;
  // stage 7: normalized magnitudes
  logic v7, zero7;
  logic [NLANE-1:0][MAG_W-1:0] m7;
  logic [NLANE-1:0] neg7;
  // stage 8: squares
  logic v8, zero8;
  logic [NLANE-1:0][MAG_W-1:0] m8;
  logic [2*MAG_W-1:0] sq8 [NLANE];
  logic [NLANE-1:0] neg8;
  // stage 9: sum of squares
  logic v9, zero9;
  logic [NLANE-1:0][MAG_W-1:0] m9;
  logic [RAD_W-1:0] n2_9;
  logic [NLANE-1:0] neg9;

  logic [5:0]  p_next;
  logic [50:0] mx_next;
  logic [NLANE-1:0] neg_next;
  logic [50:0] m_next [NLANE];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0;
    end else if (adv) begin
      v1 <= item_valid; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
      v6 <= v5; v7 <= v6; v8 <= v7; v9 <= v8;
    end
  end

  always_comb begin
    mx_next = '0;
    for (int l = 0; l < NLANE; l++) begin
      neg_next[l] = r4[l][51];
      m_next[l]   = r4[l][51] ? 51'(-r4[l]) : 51'(r4[l]);
    end
    for (int l = 0; l < NLANE; l++) begin
      if (m_next[l] > mx_next) mx_next = m_next[l];
    end
    p_next = '0;
    for (int i = 0; i < 51; i++) begin
      if (mx5[i]) p_next = 6'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ww <= 32'(item.quat_w) * 32'(item.quat_w);
      xx <= 32'(item.quat_x) * 32'(item.quat_x);
      yy <= 32'(item.quat_y) * 32'(item.quat_y);
      zz <= 32'(item.quat_z) * 32'(item.quat_z);
      xa <= 32'(item.quat_x) * 32'(item.vec_x);
      yb <= 32'(item.quat_y) * 32'(item.vec_y);
      zc <= 32'(item.quat_z) * 32'(item.vec_z);
      yc <= 32'(item.quat_y) * 32'(item.vec_z);
      zb <= 32'(item.quat_z) * 32'(item.vec_y);
      za <= 32'(item.quat_z) * 32'(item.vec_x);
      xc <= 32'(item.quat_x) * 32'(item.vec_z);
      xb <= 32'(item.quat_x) * 32'(item.vec_y);
      ya <= 32'(item.quat_y) * 32'(item.vec_x);
      w1 <= item.quat_w; x1 <= item.quat_x; y1 <= item.quat_y; z1 <= item.quat_z;
      a1 <= item.vec_x;  b1 <= item.vec_y;  c1 <= item.vec_z;

      d2  <= 34'(ww) - (34'(xx) + 34'(yy) + 34'(zz));
      e2  <= 34'(xa) + 34'(yb) + 34'(zc);
      cx2 <= 33'(yc) - 33'(zb);
      cy2 <= 33'(za) - 33'(xc);
      cz2 <= 33'(xb) - 33'(ya);
      w2 <= w1; x2 <= x1; y2 <= y1; z2 <= z1; a2 <= a1; b2 <= b1; c2 <= c1;

      da3 <= 50'(d2) * 50'(a2);
      db3 <= 50'(d2) * 50'(b2);
      dc3 <= 50'(d2) * 50'(c2);
      ex3 <= 50'(e2) * 50'(x2);
      ey3 <= 50'(e2) * 50'(y2);
      ez3 <= 50'(e2) * 50'(z2);
      wx3 <= 50'(w2) * 50'(cx2);
      wy3 <= 50'(w2) * 50'(cy2);
      wz3 <= 50'(w2) * 50'(cz2);

      r4[0] <= 52'(da3) + (52'(ex3) <<< 1) + (52'(wx3) <<< 1);
      r4[1] <= 52'(db3) + (52'(ey3) <<< 1) + (52'(wy3) <<< 1);
      r4[2] <= 52'(dc3) + (52'(ez3) <<< 1) + (52'(wz3) <<< 1);

      for (int l = 0; l < NLANE; l++) m5[l] <= m_next[l];
      mx5   <= mx_next;
      neg5  <= neg_next;
      zero5 <= mx_next == '0;

      for (int l = 0; l < NLANE; l++) m6[l] <= m5[l];
      p6    <= p_next;
      neg6  <= neg5;
      zero6 <= zero5;

      // bring the largest magnitude into [2^29, 2^30)
      for (int l = 0; l < NLANE; l++) begin
        if (p6 >= 6'd29) m7[l] <= MAG_W'(m6[l] >> (p6 - 6'd29));
        else             m7[l] <= MAG_W'(m6[l] << (6'd29 - p6));
      end
      neg7  <= neg6;
      zero7 <= zero6;

      for (int l = 0; l < NLANE; l++) sq8[l] <= (2*MAG_W)'(m7[l]) * (2*MAG_W)'(m7[l]);
      m8    <= m7;
      neg8  <= neg7;
      zero8 <= zero7;

      n2_9  <= RAD_W'(sq8[0]) + RAD_W'(sq8[1]) + RAD_W'(sq8[2]);
      m9    <= m8;
      neg9  <= neg8;
      zero9 <= zero8;
    end
  end

  logic                        vs;
  logic [ROOT_W-1:0]           n_s;
  logic [SIDE1_W-1:0]          side_s;
  logic [NLANE-1:0][MAG_W-1:0] m_s;
  logic [NLANE-1:0]            neg_s;
  logic                        zero_s;

  qrv_isqrt #(.SIDE_W(SIDE1_W)) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .vld_in   (v9),
    .rad      (n2_9),
    .side_in  ({m9, neg9, zero9}),
    .vld_out  (vs),
    .root     (n_s),
    .side_out (side_s)
  );

  assign {m_s, neg_s, zero_s} = side_s;

  logic                        vd;
  logic [NLANE-1:0][QUO_W-1:0] q_d;
  logic [SIDE2_W-1:0]          side_d;
  logic [NLANE-1:0]            neg_d;
  logic                        zero_d;

  qrv_div #(.SIDE_W(SIDE2_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .vld_in   (vs),
    .n        (n_s),
    .m        (m_s),
    .side_in  ({neg_s, zero_s}),
    .vld_out  (vd),
    .q        (q_d),
    .side_out (side_d)
  );

  assign {neg_d, zero_d} = side_d;

  logic [VAL_W-1:0] o_next [NLANE];
  logic [QUO_W-1:0] qc;

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      qc        = (q_d[l] > ONE_Q14) ? ONE_Q14 : q_d[l];
      o_next[l] = zero_d ? '0 : (neg_d[l] ? -VAL_W'(qc) : VAL_W'(qc));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.out_x      <= o_next[0];
      result.out_y      <= o_next[1];
      result.out_z      <= o_next[2];
      result.degenerate <= zero_d;
    end
  end

endmodule

@@ sv/qrv_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps

module qrv_isqrt import qrv_pkg::*; #(
  parameter int SIDE_W = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              vld_in,
  input  logic [RAD_W-1:0]  rad,
  input  logic [SIDE_W-1:0] side_in,
  output logic              vld_out,
  output logic [ROOT_W-1:0] root,
  output logic [SIDE_W-1:0] side_out
);

  localparam int NB = ROOT_W;

  logic [RAD_W-1:0]  rem_r  [NB];
  logic [ROOT_W-1:0] root_r [NB];
  logic [SIDE_W-1:0] side_r [NB];
  logic              vld_r  [NB];

  logic [RAD_W-1:0]  cur_rem  [NB];
  logic [ROOT_W-1:0] cur_root [NB];
  logic [SIDE_W-1:0] cur_side [NB];
  logic              cur_vld  [NB];
  logic [63:0]       trial    [NB];
  logic              ge       [NB];

  always_comb begin
    cur_rem[0]  = rad;
    cur_root[0] = '0;
    cur_side[0] = side_in;
    cur_vld[0]  = vld_in;
    for (int k = 1; k < NB; k++) begin
      cur_rem[k]  = rem_r[k-1];
      cur_root[k] = root_r[k-1];
      cur_side[k] = side_r[k-1];
      cur_vld[k]  = vld_r[k-1];
    end
    // (res + 2^i)^2 - res^2 = res * 2^(i+1) + 2^(2i)
    for (int k = 0; k < NB; k++) begin
      trial[k] = (64'(cur_root[k]) << (NB - k)) + (64'd1 << (2 * (NB - 1 - k)));
      ge[k]    = 64'(cur_rem[k]) >= trial[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NB; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < NB; k++) vld_r[k] <= cur_vld[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NB; k++) begin
        side_r[k] <= cur_side[k];
        if (ge[k]) begin
          rem_r[k]  <= cur_rem[k] - trial[k][RAD_W-1:0];
          root_r[k] <= cur_root[k] | (ROOT_W'(1) << (NB - 1 - k));
        end else begin
          rem_r[k]  <= cur_rem[k];
          root_r[k] <= cur_root[k];
        end
      end
    end
  end

  assign vld_out  = vld_r[NB-1];
  assign root     = root_r[NB-1];
  assign side_out = side_r[NB-1];

endmodule

@@ sv/qrv_div.sv @@
// Pipelined rounding divider for three lanes sharing one divisor.
`timescale 1ns / 1ps

module qrv_div import qrv_pkg::*; #(
  parameter int SIDE_W = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         vld_in,
  input  logic [ROOT_W-1:0]            n,
  input  logic [NLANE-1:0][MAG_W-1:0]  m,
  input  logic [SIDE_W-1:0]            side_in,
  output logic                         vld_out,
  output logic [NLANE-1:0][QUO_W-1:0]  q,
  output logic [SIDE_W-1:0]            side_out
);

  localparam int NB  = QUO_W;
  localparam int NUM_W = MAG_W + 15;

  logic [NLANE-1:0][NUM_W-1:0] rem_r [NB];
  logic [NLANE-1:0][QUO_W-1:0] quo_r [NB];
  logic [ROOT_W-1:0]           n_r   [NB];
  logic [SIDE_W-1:0]           side_r[NB];
  logic                        vld_r [NB];

  logic [NLANE-1:0][NUM_W-1:0] cur_rem [NB];
  logic [NLANE-1:0][QUO_W-1:0] cur_quo [NB];
  logic [ROOT_W-1:0]           cur_n   [NB];
  logic [SIDE_W-1:0]           cur_side[NB];
  logic                        cur_vld [NB];
  logic [NUM_W:0]              dsh     [NB];

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      // numerator m * 2^14 + n / 2
      cur_rem[0][l] = (NUM_W'(m[l]) << 14) + NUM_W'(n[ROOT_W-1:1]);
    end
    cur_quo[0]  = '0;
    cur_n[0]    = n;
    cur_side[0] = side_in;
    cur_vld[0]  = vld_in;
    for (int k = 1; k < NB; k++) begin
      cur_rem[k]  = rem_r[k-1];
      cur_quo[k]  = quo_r[k-1];
      cur_n[k]    = n_r[k-1];
      cur_side[k] = side_r[k-1];
      cur_vld[k]  = vld_r[k-1];
    end
    for (int k = 0; k < NB; k++) begin
      dsh[k] = (NUM_W'(cur_n[k]) + (NUM_W+1)'(0)) << (NB - 1 - k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NB; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < NB; k++) vld_r[k] <= cur_vld[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NB; k++) begin
        n_r[k]    <= cur_n[k];
        side_r[k] <= cur_side[k];
        for (int l = 0; l < NLANE; l++) begin
          if ((NUM_W+1)'(cur_rem[k][l]) >= dsh[k]) begin
            rem_r[k][l] <= cur_rem[k][l] - dsh[k][NUM_W-1:0];
            quo_r[k][l] <= cur_quo[k][l] | (QUO_W'(1) << (NB - 1 - k));
          end else begin
            rem_r[k][l] <= cur_rem[k][l];
            quo_r[k][l] <= cur_quo[k][l];
          end
        end
      end
    end
  end

  assign vld_out  = vld_r[NB-1];
  assign q        = quo_r[NB-1];
  assign side_out = side_r[NB-1];

endmodule

@@ sv/qrv_check.sv @@
// Port-level checks for the quaternion vector rotation block, bound to the top level.
`timescale 1ns / 1ps

module qrv_check import qrv_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_stall,
  input item_t   item,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    item_stall == (result_valid && result_stall))
    else $error("input stall does not follow output stall");

  a_degen: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.degenerate |->
      result.out_x == 0 && result.out_y == 0 && result.out_z == 0)
    else $error("degenerate result not zero");

  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      result.out_x <= 16384 && result.out_x >= -16384 &&
      result.out_y <= 16384 && result.out_y >= -16384 &&
      result.out_z <= 16384 && result.out_z >= -16384)
    else $error("result out of unit range");

endmodule

bind quaternion_rotate_vector qrv_check u_qrv_check (.*);

@@ tb/quaternion_rotate_vector_tb.sv @@
// Self-checking testbench for the quaternion vector rotation pipeline.
`timescale 1ns / 1ps

module quaternion_rotate_vector_tb;
  import qrv_pkg::*;

  localparam int LATENCY = 56;
  localparam int N_RANDOM = 1930;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b1;
  result_t result;

  result_t rotated_q[$];
  int      errors = 0;
  int      n_sent = 0;
  int      n_checked = 0;
  int      n_degen = 0;
  int      n_sat = 0;
  bit      send_done = 0;
  bit      long_hold = 0;

  quaternion_rotate_vector u_top (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Exact rotation, then scale to unit length in Q1.14.
  function automatic result_t rotate_unit(item_t it);
    longint w, x, y, z, a, b, c, d, e, cx, cy, cz;
    longint r[3];
    longint unsigned m[3], mx, n2, n, q, res, bitv, rem;
    bit neg[3];
    result_t o;
    w = it.quat_w; x = it.quat_x; y = it.quat_y; z = it.quat_z;
    a = it.vec_x; b = it.vec_y; c = it.vec_z;
    d = w * w - (x * x + y * y + z * z);
    e = x * a + y * b + z * c;
    cx = y * c - z * b;
    cy = z * a - x * c;
    cz = x * b - y * a;
    r[0] = d * a + 2 * e * x + 2 * w * cx;
    r[1] = d * b + 2 * e * y + 2 * w * cy;
    r[2] = d * c + 2 * e * z + 2 * w * cz;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = r[i] < 0;
      m[i] = neg[i] ? -r[i] : r[i];
      if (m[i] > mx) mx = m[i];
    end
    o = '0;
    if (mx == 0) begin
      o.degenerate = 1'b1;
      return o;
    end
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    n2 = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    rem = n2; res = 0; bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    n = res;
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * 16384 + (n >> 1)) / n;
      if (q > 16384) q = 16384;
      case (i)
        0: o.out_x = neg[i] ? -16'(q) : 16'(q);
        1: o.out_y = neg[i] ? -16'(q) : 16'(q);
        default: o.out_z = neg[i] ? -16'(q) : 16'(q);
      endcase
    end
    return o;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] rand_val();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 3) - 1);
      3: return 16'($urandom_range(16384) - 8192);
      default: return 16'($urandom);
    endcase
  endfunction

  // Directed rows: the flag marks rows whose expected result is typed in.
  typedef struct {
    item_t   stim;
    bit      fixed;
    result_t want;
  } row_t;

  row_t rows[$];

  function automatic item_t mk(int w, int x, int y, int z, int a, int b, int c);
    item_t t;
    t.quat_w = 16'(w); t.quat_x = 16'(x); t.quat_y = 16'(y); t.quat_z = 16'(z);
    t.vec_x = 16'(a); t.vec_y = 16'(b); t.vec_z = 16'(c);
    return t;
  endfunction

  function automatic result_t rs(int x, int y, int z, bit dg);
    result_t t;
    t.out_x = 16'(x); t.out_y = 16'(y); t.out_z = 16'(z); t.degenerate = dg;
    return t;
  endfunction

  task automatic add_row(item_t t, bit fx, result_t r);
    row_t rw;
    rw.stim = t; rw.fixed = fx; rw.want = r;
    rows.push_back(rw);
  endtask

  task automatic send(item_t t, result_t exp_r);
    item_valid <= 1'b1;
    item <= t;
    rotated_q.push_back(exp_r);
    @(posedge clk);
    while (item_stall) @(posedge clk);
    n_sent++;
    if (exp_r.degenerate) n_degen++;
  endtask

  task automatic pause_send();
    int g;
    g = gap_len();
    if (g > 0) begin
      item_valid <= 1'b0;
      item <= item_t'({$urandom, $urandom, $urandom, $urandom});
      repeat (g) @(posedge clk);
    end
  endtask

  initial begin
    item_t t;
    int sw;
    add_row(mk(0, 0, 0, 0, 16384, 0, 0), 1, rs(0, 0, 0, 1));
    add_row(mk(16384, 0, 0, 0, 0, 0, 0), 1, rs(0, 0, 0, 1));
    add_row(mk(16384, 0, 0, 0, 16384, 0, 0), 1, rs(16384, 0, 0, 0));
    add_row(mk(16384, 0, 0, 0, 0, -32768, 0), 1, rs(0, -16384, 0, 0));
    add_row(mk(-32768, 0, 0, 0, 0, 0, 32767), 1, rs(0, 0, 16384, 0));
    add_row(mk(0, 16384, 0, 0, 0, 16384, 0), 1, rs(0, -16384, 0, 0));
    add_row(mk(0, 0, 0, 16384, 16384, 0, 0), 1, rs(-16384, 0, 0, 0));
    add_row(mk(11585, 0, 0, 11585, 16384, 0, 0), 0, '0);
    add_row(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768), 0, '0);
    add_row(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767), 0, '0);
    add_row(mk(32767, -32768, 32767, -32768, 1, -1, 1), 0, '0);
    add_row(mk(1, 0, 0, 0, 1, 1, 1), 0, '0);
    add_row(mk(0, 1, 1, 1, 0, 0, 1), 0, '0);
    add_row(mk(-1, 0, -1, 0, -32768, 32767, 0), 0, '0);
    add_row(mk(16384, 16384, 16384, 16384, 3, 4, 0), 0, '0);
    add_row(mk(0, 0, 0, 0, 0, 0, 0), 1, rs(0, 0, 0, 1));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      send(rows[i].stim, rows[i].fixed ? rows[i].want : rotate_unit(rows[i].stim));
      if (i % 4 == 3) pause_send();
    end
    for (int k = 0; k < N_RANDOM; k++) begin
      sw = $urandom_range(9);
      if (sw < 2) begin
        t = item_t'({$urandom, $urandom, $urandom, $urandom});
      end else if (sw == 2) begin
        // zero quaternion or zero vector
        t = mk(rand_val(), rand_val(), rand_val(), rand_val(), 0, 0, 0);
        if ($urandom_range(1)) begin
          t = item_t'({$urandom, $urandom, $urandom, $urandom});
          t.quat_w = '0; t.quat_x = '0; t.quat_y = '0; t.quat_z = '0;
        end
      end else begin
        t = mk(rand_val(), rand_val(), rand_val(), rand_val(),
               rand_val(), rand_val(), rand_val());
      end
      if (k == 300) long_hold = 1;
      send(t, rotate_unit(t));
      if ($urandom_range(3) == 0) pause_send();
    end
    item_valid <= 1'b0;
    send_done = 1;
  end

  // Receiver: random stalls, one long hold-off to fill the pipeline.
  initial begin
    int g;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        long_hold = 0;
        result_stall <= 1'b1;
        repeat (200) @(posedge clk);
      end
      g = ($urandom_range(2) == 0) ? gap_len() : 0;
      if (g > 0) begin
        result_stall <= 1'b1;
        repeat (g) @(posedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && result_valid && !result_stall) begin
      if (rotated_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, result);
        errors++;
      end else begin
        exp_r = rotated_q.pop_front();
        n_checked++;
        if (result.out_x == 16384 || result.out_x == -16384) n_sat++;
        if (result.out_x !== exp_r.out_x)
          $display("%0t: out_x expected %0d got %0d", $time, exp_r.out_x, result.out_x);
        if (result.out_y !== exp_r.out_y)
          $display("%0t: out_y expected %0d got %0d", $time, exp_r.out_y, result.out_y);
        if (result.out_z !== exp_r.out_z)
          $display("%0t: out_z expected %0d got %0d", $time, exp_r.out_z, result.out_z);
        if (result.degenerate !== exp_r.degenerate)
          $display("%0t: degenerate expected %0b got %0b", $time,
                   exp_r.degenerate, result.degenerate);
        if (result !== exp_r) errors++;
      end
    end
  end

  initial begin
    wait (send_done);
    while (rotated_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d transactions, checked %0d results (%0d degenerate, %0d at full scale x).",
             n_sent, n_checked, n_degen, n_sat);
    if (errors == 0 && rotated_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding", rotated_q.size());
    $display("Verification failed");
    $finish;
  end

endmodule

@@ files.f @@
sv/qrv_pkg.sv
sv/qrv_isqrt.sv
sv/qrv_div.sv
sv/quaternion_rotate_vector.sv
sv/qrv_check.sv
tb/quaternion_rotate_vector_tb.sv
